### hw/rtl/mngs_pkg.sv
package mngs_pkg;

  // Number of gate ports and width of the gate output field
  localparam int unsigned PortCount = 8;
  localparam int unsigned GateW     = 8;

  // Configuration register fields
  localparam int unsigned ChanW     = 4;
  localparam int unsigned NoteW     = 7;
  localparam int unsigned ChansW    = 32;
  localparam int unsigned NotesW    = 56;
  localparam int unsigned CfgDataW  = 56;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned NoteBase  = 60;

  // Message queue between parser and gate unit
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRIG_CHANNELS = 2'd0,
    CFG_TRIG_NOTES    = 2'd1,
    CFG_INVERT_MASK   = 2'd2
  } cfg_reg_e;

  // Upper nibble of a MIDI status byte
  localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
  localparam logic [3:0] ST_NOTE_ON    = 4'h9;
  localparam logic [3:0] ST_CONTROL    = 4'hB;
  localparam logic [3:0] ST_PROGRAM    = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
  localparam logic [3:0] ST_PITCH_BEND = 4'hE;
  localparam logic [3:0] ST_SYSTEM     = 4'hF;

  // One classified message handed from parser to gate unit (one per byte)
  typedef struct packed {
    logic             done;     // byte completed a reportable message
    logic [7:0]       status;   // running status at completion
    logic [NoteW-1:0] note;     // first parameter
    logic             vel_nz;   // second parameter is nonzero
  } msg_t;

  // Reset value of the trigger notes: 60+i for each port
  function automatic logic [NotesW-1:0] notes_reset();
    logic [NotesW-1:0] v;
    v = '0;
    for (int i = 0; i < NotesW / NoteW; i++) begin
      v[i*NoteW +: NoteW] = NoteW'(NoteBase + i);
    end
    return v;
  endfunction

endpackage

### hw/rtl/mngs_parser.sv
module mngs_parser import mngs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output msg_t       msg_o
);

  logic [7:0]       run_status_q, run_status_d;
  logic [1:0]       params_exp_q, params_exp_d;
  logic             param_idx_q, param_idx_d;
  logic [NoteW-1:0] store0_q, store0_d;
  logic [NoteW-1:0] store1_q, store1_d;

  logic [3:0] byte_hi;
  logic [3:0] rs_hi;
  logic [1:0] idx_next;

  assign byte_hi  = rx_byte_i[7:4];
  assign rs_hi    = run_status_q[7:4];
  assign idx_next = {1'b0, param_idx_q} + 2'd1;

  always_comb begin
    run_status_d = run_status_q;
    params_exp_d = params_exp_q;
    param_idx_d  = param_idx_q;
    store0_d     = store0_q;
    store1_d     = store1_q;
    msg_o        = '0;
    if (rx_byte_i[7]) begin
      // system bytes leave running status and position alone
      if (byte_hi != ST_SYSTEM) begin
        run_status_d = rx_byte_i;
        params_exp_d = (byte_hi == ST_PROGRAM || byte_hi == ST_CHAN_PRESS) ? 2'd1 : 2'd2;
        param_idx_d  = 1'b0;
      end
    end else begin
      if (param_idx_q) store1_d = rx_byte_i[NoteW-1:0];
      else             store0_d = rx_byte_i[NoteW-1:0];
      if (idx_next >= params_exp_q) begin
        param_idx_d = 1'b0;
        if (rs_hi inside {ST_NOTE_OFF, ST_NOTE_ON, ST_CONTROL, ST_PITCH_BEND}) begin
          msg_o.done = 1'b1;
        end
      end else begin
        param_idx_d = idx_next[0];
      end
    end
    msg_o.status = msg_o.done ? run_status_q : 8'h00;
    msg_o.note   = store0_d;
    msg_o.vel_nz = (store1_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_status_q <= '0;
      params_exp_q <= '0;
      param_idx_q  <= 1'b0;
      store0_q     <= '0;
      store1_q     <= '0;
    end else if (accept_i) begin
      run_status_q <= run_status_d;
      params_exp_q <= params_exp_d;
      param_idx_q  <= param_idx_d;
      store0_q     <= store0_d;
      store1_q     <= store1_d;
    end
  end

endmodule

### hw/rtl/mngs_queue.sv
module mngs_queue import mngs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  msg_t push_msg_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output msg_t head_o
);

  msg_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_msg_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCntW'(1);
        2'b01:   count_q <= count_q - QCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### hw/rtl/mngs_gate.sv
module mngs_gate import mngs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_write_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                q_valid_i,
  input  msg_t                q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [GateW-1:0]    gate_out_o,
  output logic                message_done_o,
  output logic [7:0]          message_status_o
);

  logic [ChansW-1:0]    trig_chans_q;
  logic [NotesW-1:0]    trig_notes_q;
  logic [GateW-1:0]     invert_q;
  logic [PortCount-1:0] held_q, held_d;
  logic [PortCount-1:0] match;
  logic [3:0]           msg_hi;

  logic             out_valid_q;
  logic [GateW-1:0] gate_q;
  logic             done_q;
  logic [7:0]       status_q;

  assign msg_hi  = q_head_i.status[7:4];
  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    for (int i = 0; i < PortCount; i++) begin
      match[i] = (trig_chans_q[i*ChanW +: ChanW] == q_head_i.status[ChanW-1:0]) &&
                 (trig_notes_q[i*NoteW +: NoteW] == q_head_i.note);
    end
  end

  always_comb begin
    held_d = held_q;
    if (q_head_i.done) begin
      if (msg_hi == ST_NOTE_ON && q_head_i.vel_nz) begin
        held_d = held_q | match;
      end else if (msg_hi == ST_NOTE_ON || msg_hi == ST_NOTE_OFF) begin
        held_d = held_q & ~match;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_chans_q <= '0;
      trig_notes_q <= notes_reset();
      invert_q     <= '0;
    end else if (cfg_write_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TRIG_CHANNELS: trig_chans_q <= cfg_data_i[ChansW-1:0];
        CFG_TRIG_NOTES:    trig_notes_q <= cfg_data_i[NotesW-1:0];
        CFG_INVERT_MASK:   invert_q     <= cfg_data_i[GateW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        held_q      <= held_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      gate_q   <= GateW'(held_d ^ invert_q[PortCount-1:0]);
      done_q   <= q_head_i.done;
      status_q <= q_head_i.status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign gate_out_o       = gate_q;
  assign message_done_o   = done_q;
  assign message_status_o = status_q;

endmodule

### hw/rtl/midi_note_gate_switcher_core.sv
// Path: the parser pushes each accepted byte's message into the queue on the accept edge,
//   and the gate unit loads the output register when it pops that entry from the queue.
// Throughput: one byte per cycle while results are taken; the queue and output register
//   absorb short output stalls, and the input stalls only while the queue is full.
// Reset (asynchronous, active low): clears running status, parameter position, gates,
//   queue and output valid; trigger notes return to 60+i, channels and invert mask to 0.
module midi_note_gate_switcher_core import mngs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // byte request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  // result request channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [GateW-1:0]    gate_out_o,
  output logic                message_done_o,
  output logic [7:0]          message_status_o
);

  logic in_accept;
  msg_t parsed_msg;
  logic q_full;
  logic q_valid;
  logic q_pop;
  msg_t q_head;

  // Registers are always writable; the user must write only while the block is idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  // Hold off new bytes only while the message queue has no free slot.
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Front: track running status and parameters, classify each byte into a message.
  mngs_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .rx_byte_i (rx_byte_i),
    .msg_o     (parsed_msg)
  );

  // Short queue so parsing and gate update stall independently.
  mngs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_accept),
    .push_msg_i (parsed_msg),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // Back: match ports, advance gate bits, present the result request.
  mngs_gate u_gate (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_write_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .q_valid_i        (q_valid),
    .q_head_i         (q_head),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .gate_out_o       (gate_out_o),
    .message_done_o   (message_done_o),
    .message_status_o (message_status_o)
  );

endmodule
